>>> design/byte_ring_buffer_defines.svh
// assertion macros used by the byte ring buffer back end
`ifndef BYTE_RING_BUFFER_DEFINES_SVH
`define BYTE_RING_BUFFER_DEFINES_SVH

// invariant checked at every rising clock edge outside reset
`define BRB_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// implication checked at every rising clock edge outside reset
`define BRB_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> design/brb_pkg.sv
// shared types and constants for the byte ring buffer
package brb_pkg;

  localparam int OP_W       = 3;
  localparam int DATA_W     = 8;
  localparam int LEN_W      = 7;
  localparam int USED_W     = 12;
  localparam int SIZE_W     = 13;
  localparam int SIZE_RESET = 4096;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
  localparam logic [OP_W-1:0] OP_READ    = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
  localparam logic [OP_W-1:0] OP_DISCARD = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

  typedef enum logic [2:0] {
    K_WRITE,
    K_READ,
    K_PEEK,
    K_DISCARD,
    K_CLEAR,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [DATA_W-1:0]   data;
    logic [LEN_W-1:0]    len;
  } cmd_t;

endpackage

>>> design/brb_cmd_if.sv
// command channel carrying one operation item
interface brb_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [brb_pkg::OP_W-1:0]   op;
  logic [brb_pkg::DATA_W-1:0] data;
  logic [brb_pkg::LEN_W-1:0]  length;

  modport source (output valid, output op, output data, output length, input ready);
  modport sink   (input valid, input op, input data, input length, output ready);
endinterface

>>> design/brb_rsp_if.sv
// result channel carrying one result item
interface brb_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [brb_pkg::DATA_W-1:0] byte_out;
  logic                       has_data;
  logic                       accepted;
  logic [brb_pkg::LEN_W-1:0]  taken;
  logic [brb_pkg::USED_W-1:0] used;
  logic [brb_pkg::USED_W-1:0] spare;
  logic                       last;

  modport source (output valid, output byte_out, output has_data, output accepted,
                  output taken, output used, output spare, output last, input ready);
  modport sink   (input valid, input byte_out, input has_data, input accepted,
                  input taken, input used, input spare, input last, output ready);
endinterface

>>> design/brb_cfg_if.sv
// configuration write channel for the size register
interface brb_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [brb_pkg::SIZE_W-1:0] size_in_use;

  modport source (output valid, output size_in_use, input ready);
  modport sink   (input valid, input size_in_use, output ready);
endinterface

>>> design/brb_ram.sv
// generic simple dual-port ram with registered read
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/brb_front.sv
// front end: accepts command items, decodes the op and clamps the burst length
module brb_front #(
  parameter int MAX_BURST = 64
) (
  brb_cmd_if.sink         cmd,
  input  logic            full,
  output logic            push,
  output brb_pkg::cmd_t   push_cmd
);

  localparam int LW = brb_pkg::LEN_W;

  assign cmd.ready = !full;
  assign push      = cmd.valid && !full;

  always_comb begin
    push_cmd.data = cmd.data;
    push_cmd.len  = (cmd.length > LW'(MAX_BURST)) ? LW'(MAX_BURST) : cmd.length;
    unique case (cmd.op)
      brb_pkg::OP_WRITE:   push_cmd.kind = brb_pkg::K_WRITE;
      brb_pkg::OP_READ:    push_cmd.kind = brb_pkg::K_READ;
      brb_pkg::OP_PEEK:    push_cmd.kind = brb_pkg::K_PEEK;
      brb_pkg::OP_DISCARD: push_cmd.kind = brb_pkg::K_DISCARD;
      brb_pkg::OP_CLEAR:   push_cmd.kind = brb_pkg::K_CLEAR;
      default:             push_cmd.kind = brb_pkg::K_NOP;
    endcase
  end

endmodule

>>> design/brb_queue.sv
// short command queue between the front end and the back end
module brb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  brb_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output brb_pkg::cmd_t pop_cmd
);

  localparam int DEPTH = brb_pkg::QUEUE_DEPTH;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  brb_pkg::cmd_t entries [DEPTH];
  logic [IW-1:0] wptr;
  logic [IW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign pop_cmd = entries[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_cmd;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == IW'(DEPTH - 1)) ? '0 : wptr + IW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == IW'(DEPTH - 1)) ? '0 : rptr + IW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> design/brb_back.sv
// back end: pointers, byte store, size register and result sequencing
`include "byte_ring_buffer_defines.svh"

module brb_back #(
  parameter int MEM_DEPTH = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  brb_pkg::cmd_t q_cmd,
  output logic          pop,
  brb_rsp_if.source     rsp,
  brb_cfg_if.sink       cfg
);

  localparam int PTR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SZ_W  = PTR_W + 1;
  localparam int SW    = brb_pkg::SIZE_W;
  localparam int CMP_W = (SZ_W > SW) ? SZ_W : SW;
  localparam int LW    = brb_pkg::LEN_W;
  localparam int UW    = brb_pkg::USED_W;
  localparam int DW    = brb_pkg::DATA_W;
  localparam int CN_W  = (PTR_W > LW) ? PTR_W : LW;
  localparam int RESET_SIZE =
    (brb_pkg::SIZE_RESET > MEM_DEPTH) ? MEM_DEPTH : brb_pkg::SIZE_RESET;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_ADDR,
    S_RD_DATA
  } state_t;

  state_t           state, state_next;
  logic [SZ_W-1:0]  size, size_next;
  logic [PTR_W-1:0] rd_pos, rd_pos_next;
  logic [PTR_W-1:0] wr_pos, wr_pos_next;
  logic [PTR_W-1:0] used, used_next;
  logic [PTR_W-1:0] cur, cur_next;
  logic [LW-1:0]    cnt, cnt_next;
  logic [LW-1:0]    burst, burst_next;

  logic             ov, ov_next;
  logic [DW-1:0]    res_byte, res_byte_next;
  logic             res_has, res_has_next;
  logic             res_acc, res_acc_next;
  logic [LW-1:0]    res_taken, res_taken_next;
  logic [UW-1:0]    res_used, res_used_next;
  logic [UW-1:0]    res_spare, res_spare_next;
  logic             res_last, res_last_next;

  logic             out_free;
  logic [LW-1:0]    n;
  logic             write_ok;
  logic [SZ_W-1:0]  sum_rd;
  logic [SZ_W-1:0]  sum_wr;
  logic [SZ_W-1:0]  sum_cur;
  logic [PTR_W-1:0] rd_adv;
  logic [PTR_W-1:0] wr_adv;
  logic [PTR_W-1:0] cur_adv;
  logic [CMP_W-1:0] cfg_v;
  logic [SZ_W-1:0]  size_clamped;
  logic [SZ_W-1:0]  spare_full;
  logic [SZ_W-1:0]  ptr_used;
  logic             ram_we;
  logic             ram_re;
  logic [DW-1:0]    ram_rdata;

  brb_ram #(
    .WIDTH (DW),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_pos),
    .wdata (q_cmd.data),
    .re    (ram_re),
    .raddr (cur),
    .rdata (ram_rdata)
  );

  assign cfg.ready = 1'b1;
  assign out_free  = !ov || rsp.ready;

  assign n        = (CN_W'(q_cmd.len) < CN_W'(used)) ? q_cmd.len : LW'(used);
  assign write_ok = ({1'b0, used} + SZ_W'(1)) < size;

  // wrapped position advances; every sum stays below twice the size
  assign sum_rd  = {1'b0, rd_pos} + SZ_W'(n);
  assign sum_wr  = {1'b0, wr_pos} + SZ_W'(1);
  assign sum_cur = {1'b0, cur} + SZ_W'(1);
  assign rd_adv  = PTR_W'((sum_rd >= size) ? sum_rd - size : sum_rd);
  assign wr_adv  = PTR_W'((sum_wr >= size) ? sum_wr - size : sum_wr);
  assign cur_adv = PTR_W'((sum_cur >= size) ? sum_cur - size : sum_cur);

  assign cfg_v = CMP_W'(cfg.size_in_use);
  always_comb begin
    if (cfg_v < CMP_W'(2)) begin
      size_clamped = SZ_W'(2);
    end else if (cfg_v > CMP_W'(MEM_DEPTH)) begin
      size_clamped = SZ_W'(MEM_DEPTH);
    end else begin
      size_clamped = SZ_W'(cfg_v);
    end
  end

  assign ptr_used = (wr_pos >= rd_pos) ? SZ_W'(wr_pos - rd_pos)
                                       : size - SZ_W'(rd_pos) + SZ_W'(wr_pos);

  assign spare_full = size - SZ_W'(1) - {1'b0, used_next};

  always_comb begin
    state_next     = state;
    size_next      = size;
    rd_pos_next    = rd_pos;
    wr_pos_next    = wr_pos;
    used_next      = used;
    cur_next       = cur;
    cnt_next       = cnt;
    burst_next     = burst;
    ov_next        = ov && !rsp.ready;
    res_byte_next  = res_byte;
    res_has_next   = res_has;
    res_acc_next   = res_acc;
    res_taken_next = res_taken;
    res_last_next  = res_last;
    pop            = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          if ((q_cmd.kind == brb_pkg::K_READ || q_cmd.kind == brb_pkg::K_PEEK)
              && n != '0) begin
            pop        = 1'b1;
            cur_next   = rd_pos;
            cnt_next   = n;
            burst_next = n;
            if (q_cmd.kind == brb_pkg::K_READ) begin
              rd_pos_next = rd_adv;
              used_next   = used - PTR_W'(n);
            end
            state_next = S_RD_ADDR;
          end else if (out_free) begin
            pop            = 1'b1;
            ov_next        = 1'b1;
            res_byte_next  = '0;
            res_has_next   = 1'b0;
            res_acc_next   = 1'b0;
            res_taken_next = '0;
            res_last_next  = 1'b1;
            unique case (q_cmd.kind)
              brb_pkg::K_WRITE: begin
                res_acc_next = write_ok;
                if (write_ok) begin
                  ram_we      = 1'b1;
                  wr_pos_next = wr_adv;
                  used_next   = used + PTR_W'(1);
                end
              end
              brb_pkg::K_DISCARD: begin
                rd_pos_next    = rd_adv;
                used_next      = used - PTR_W'(n);
                res_taken_next = n;
              end
              brb_pkg::K_CLEAR: begin
                rd_pos_next = '0;
                wr_pos_next = '0;
                used_next   = '0;
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_RD_ADDR: begin
        ram_re     = 1'b1;
        state_next = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (out_free) begin
          ov_next        = 1'b1;
          res_byte_next  = ram_rdata;
          res_has_next   = 1'b1;
          res_acc_next   = 1'b0;
          res_taken_next = burst;
          res_last_next  = (cnt == LW'(1));
          cur_next       = cur_adv;
          cnt_next       = cnt - LW'(1);
          state_next     = (cnt == LW'(1)) ? S_IDLE : S_RD_ADDR;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (cfg.valid) begin
      size_next   = size_clamped;
      rd_pos_next = '0;
      wr_pos_next = '0;
      used_next   = '0;
    end
  end

  assign res_used_next  = UW'(used_next);
  assign res_spare_next = UW'(spare_full);

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    cnt       <= cnt_next;
    burst     <= burst_next;
    res_byte  <= res_byte_next;
    res_has   <= res_has_next;
    res_acc   <= res_acc_next;
    res_taken <= res_taken_next;
    res_last  <= res_last_next;
    if (ov_next && !(ov && !rsp.ready)) begin
      res_used  <= res_used_next;
      res_spare <= res_spare_next;
    end
    if (rst) begin
      state  <= S_IDLE;
      size   <= SZ_W'(RESET_SIZE);
      rd_pos <= '0;
      wr_pos <= '0;
      used   <= '0;
      ov     <= 1'b0;
    end else begin
      state  <= state_next;
      size   <= size_next;
      rd_pos <= rd_pos_next;
      wr_pos <= wr_pos_next;
      used   <= used_next;
      ov     <= ov_next;
    end
  end

  assign rsp.valid    = ov;
  assign rsp.byte_out = res_byte;
  assign rsp.has_data = res_has;
  assign rsp.accepted = res_acc;
  assign rsp.taken    = res_taken;
  assign rsp.used     = res_used;
  assign rsp.spare    = res_spare;
  assign rsp.last     = res_last;

  `BRB_CHECK(a_used_matches_ptrs, SZ_W'(used) == ptr_used, "fill count disagrees with pointers")
  `BRB_CHECK(a_ptrs_in_range, (SZ_W'(rd_pos) < size) && (SZ_W'(wr_pos) < size), "pointer beyond size")
  `BRB_IMPLY(a_stream_count, state != S_IDLE, cnt != '0, "burst sequencer running with zero count")

endmodule

>>> design/byte_ring_buffer.sv
// Circular byte FIFO holding at most size_in_use - 1 bytes (size clamped to
// 2..MEM_DEPTH; writing it empties the buffer). Items enter a two-entry
// command queue; write, discard, clear and unknown ops, done in the idle
// state, each give one result and sustain one item per cycle while results
// are taken. A read or peek gives a result per byte up to the bytes held
// (one if none is held or its length is 0) and takes no new item before its
// last byte; each byte passes an address and a data state, as the store's
// read port is registered. The byte store needs no clearing after reset.
module byte_ring_buffer #(
  parameter int MEM_DEPTH = 4096,
  parameter int MAX_BURST = 64
) (
  input logic     clk,
  input logic     rst,
  brb_cmd_if.sink cmd,
  brb_rsp_if.source rsp,
  brb_cfg_if.sink cfg
);

  logic          q_full;
  logic          q_push;
  brb_pkg::cmd_t q_push_cmd;
  logic          q_valid;
  logic          q_pop;
  brb_pkg::cmd_t q_pop_cmd;

  brb_front #(
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .cmd      (cmd),
    .full     (q_full),
    .push     (q_push),
    .push_cmd (q_push_cmd)
  );

  brb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (q_pop_cmd)
  );

  brb_back #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_pop_cmd),
    .pop     (q_pop),
    .rsp     (rsp),
    .cfg     (cfg)
  );

endmodule
